// ===== design/qs_pkg.sv =====
package qs_pkg;

    localparam logic [15:0] THR_RESET = 16'd32735;
    localparam logic [15:0] HALF_PI   = 16'd51472;
    localparam logic [16:0] ONE_Q15   = 17'd32768;

    localparam int NPRE    = 25;
    localparam int NDIV    = 32;
    localparam int ST_SQ0  = 4;
    localparam int ST_SQ1  = 9;
    localparam int NSQ     = 9;
    localparam int ST_SIN  = 15;
    localparam int NSERIES = 4;

    localparam logic [6:0]  SIN_K [NSERIES] = '{7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [24:0] SIN_M [NSERIES] = '{
        25'((2 ** 24) / 72), 25'((2 ** 24) / 42), 25'((2 ** 24) / 20), 25'((2 ** 24) / 6)
    };

    typedef logic signed [15:0] t_s16;
    typedef logic signed [16:0] t_s17;
    typedef logic signed [32:0] t_s33;
    typedef logic signed [49:0] t_s50;

    typedef struct packed {
        logic [33:0] v;
        logic [33:0] r;
    } t_sqrt;

    typedef struct packed {
        logic [15:0] u;
        logic [16:0] y2;
        logic [17:0] q;
        logic [16:0] s;
    } t_sin;

    typedef struct packed {
        logic              vld;
        t_s16 [3:0]        a;
        t_s17 [3:0]        b;
        logic [15:0]       t;
        t_s33 [3:0]        lp;
        t_s17 [3:0]        l;
        logic signed [33:0] dot;
        logic [15:0]       d;
        logic              lin;
        logic signed [17:0] p;
        t_sqrt [1:0]       sq;
        logic [16:0]       theta;
        t_sin [2:0]        sn;
    } t_pipe;

    typedef struct packed {
        logic        vld;
        logic        lin;
        logic        mzero;
        logic [3:0]  lneg;
        t_s16 [3:0]  a;
        t_s17 [3:0]  b;
    } t_side;

    typedef struct packed {
        logic        vld;
        logic        lin;
        logic        mzero;
        logic [3:0]  lneg;
        logic [3:0][31:0] q;
        t_s50 [3:0]  pa;
        t_s50 [3:0]  pb;
    } t_post;

    typedef struct packed {
        logic        vld;
        logic        lin;
        t_s16 [3:0]  r;
    } t_out;

    function automatic t_s50 rsh15(input t_s50 v);
        return (v + 50'sd16384) >>> 15;
    endfunction

    function automatic t_s16 sat16(input t_s50 v);
        t_s16 res;
        if (v > 50'sd32767) begin
            res = 16'sh7FFF;
        end else if (v < -50'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    function automatic t_sqrt sqrt_step(input t_sqrt x, input int m);
        t_sqrt       y;
        logic [33:0] bt;
        logic [33:0] tr;
        y  = x;
        bt = '0;
        tr = '0;
        if (m >= 0) begin
            bt = 34'd1 << (2 * m);
            tr = x.r + bt;
            if (x.v >= tr) begin
                y.v = x.v - tr;
                y.r = (x.r >> 1) + bt;
            end else begin
                y.r = x.r >> 1;
            end
        end
        return y;
    endfunction

    function automatic logic [15:0] div_const(input logic [17:0] q, input logic [24:0] m,
                                              input logic [6:0] kk);
        logic [42:0] pr;
        logic [17:0] q0;
        logic [17:0] rm;
        pr = 43'(q) * 43'(m);
        q0 = pr[41:24];
        rm = q - 18'(q0 * {11'b0, kk});
        if (rm >= {11'b0, kk}) begin
            q0 = q0 + 18'd1;
        end
        return q0[15:0];
    endfunction

    function automatic t_pipe stage_fn(input int k, input t_pipe x, input logic [15:0] thr);
        t_pipe              y;
        logic signed [33:0] dd;
        logic signed [17:0] ds;
        logic signed [17:0] ot;
        logic signed [17:0] tt;
        logic signed [17:0] ths;
        logic [15:0]        uc;
        int                 si;
        int                 sj;
        y   = x;
        ds  = $signed({2'b0, x.d});
        ot  = $signed({1'b0, ONE_Q15 - {1'b0, x.t}});
        tt  = $signed({2'b0, x.t});
        ths = $signed({1'b0, x.theta});
        dd  = '0;
        uc  = '0;
        si  = (k - ST_SIN - 1) >> 1;
        sj  = k - ST_SQ0;
        if (k == 0) begin
            for (int i = 0; i < 4; i++) begin
                y.lp[i] = x.a[i] * x.b[i];
            end
            y.t = (x.t > 16'd32768) ? 16'd32768 : x.t;
        end
        if (k == 1) begin
            y.dot = x.lp[0] + x.lp[1] + x.lp[2] + x.lp[3];
        end
        if (k == 2) begin
            if (x.dot < 0) begin
                y.dot = -x.dot;
                for (int i = 0; i < 4; i++) begin
                    y.b[i] = -x.b[i];
                end
            end
        end
        if (k == 3) begin
            dd       = (x.dot + 34'sd16384) >>> 15;
            y.d      = (dd > 34'sd32768) ? 16'd32768 : dd[15:0];
            y.lin    = y.d > thr;
            y.sq[0].v = 34'(ONE_Q15 - {1'b0, y.d}) << 15;
            y.sq[0].r = '0;
        end
        if (k >= ST_SQ0 && k < ST_SQ0 + NSQ) begin
            y.sq[0] = sqrt_step(sqrt_step(x.sq[0], 16 - 2 * sj), 15 - 2 * sj);
        end
        if (k >= ST_SQ1 && k < ST_SQ1 + NSQ) begin
            y.sq[1] = sqrt_step(sqrt_step(x.sq[1], 16 - 2 * (k - ST_SQ1)),
                                15 - 2 * (k - ST_SQ1));
        end
        if (k == 4) begin
            y.p = 18'sd2433 + 18'(rsh15(-18'sd614 * ds));
            for (int i = 0; i < 4; i++) begin
                y.lp[i] = x.a[i] * ot;
            end
        end
        if (k == 5) begin
            y.p = -18'sd6951 + 18'(rsh15(x.p * ds));
            for (int i = 0; i < 4; i++) begin
                y.lp[i] = x.lp[i] + x.b[i] * tt;
            end
        end
        if (k == 6) begin
            y.p = 18'sd51470 + 18'(rsh15(x.p * ds));
            for (int i = 0; i < 4; i++) begin
                y.l[i] = 17'(rsh15(t_s50'(x.lp[i])));
            end
        end
        if (k == 7) begin
            for (int i = 0; i < 4; i++) begin
                y.lp[i] = x.l[i] * x.l[i];
            end
        end
        if (k == 8) begin
            y.sq[1].v = 34'(x.lp[0]) + 34'(x.lp[1]) + 34'(x.lp[2]) + 34'(x.lp[3]);
            y.sq[1].r = '0;
        end
        if (k == 13) begin
            y.theta = 17'(rsh15(x.p * $signed({1'b0, x.sq[0].r[16:0]})));
        end
        if (k == 14) begin
            y.sn[0].u = x.theta[15:0];
            y.sn[1].u = 16'(rsh15(ths * ot));
            y.sn[2].u = 16'(rsh15(ths * tt));
        end
        if (k == ST_SIN) begin
            for (int j = 0; j < 3; j++) begin
                uc         = (x.sn[j].u > HALF_PI) ? HALF_PI : x.sn[j].u;
                y.sn[j].u  = uc;
                y.sn[j].y2 = 17'((34'(uc) * 34'(uc) + 34'd16384) >> 15);
                y.sn[j].s  = ONE_Q15;
            end
        end
        if (k > ST_SIN && k <= ST_SIN + 2 * NSERIES) begin
            for (int j = 0; j < 3; j++) begin
                if (((k - ST_SIN) & 1) == 1) begin
                    y.sn[j].q = 18'((34'(x.sn[j].y2) * 34'(x.sn[j].s)) >> 15)
                                + 18'(SIN_K[2'(si)] >> 1);
                end else begin
                    y.sn[j].s = ONE_Q15 - 17'(div_const(x.sn[j].q, SIN_M[2'(si)],
                                                        SIN_K[2'(si)]));
                end
            end
        end
        if (k == ST_SIN + 2 * NSERIES + 1) begin
            for (int j = 0; j < 3; j++) begin
                y.sn[j].s = 17'((34'(x.sn[j].u) * 34'(x.sn[j].s) + 34'd16384) >> 15);
            end
        end
        return y;
    endfunction

endpackage

// ===== design/qs_div.sv =====
module qs_div (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [16:0]       i_den,
    input  logic [3:0][31:0]  i_num,
    output logic [3:0][31:0]  o_quo
);

    typedef struct packed {
        logic [16:0]      den;
        logic [3:0][16:0] rem;
        logic [3:0][31:0] nq;
    } t_dstage;

    t_dstage r_stg [qs_pkg::NDIV];
    t_dstage n_stg [qs_pkg::NDIV];

    function automatic t_dstage div_step(input t_dstage x);
        t_dstage     y;
        logic [17:0] rem2;
        logic        ge;
        y    = x;
        rem2 = '0;
        ge   = 1'b0;
        for (int i = 0; i < 4; i++) begin
            rem2 = {x.rem[i], x.nq[i][31]};
            ge   = rem2 >= {1'b0, x.den};
            y.rem[i] = ge ? 17'(rem2 - {1'b0, x.den}) : rem2[16:0];
            y.nq[i]  = {x.nq[i][30:0], ge};
        end
        return y;
    endfunction

    for (genvar k = 0; k < qs_pkg::NDIV; k++) begin : g_stg
        if (k == 0) begin : g_first
            assign n_stg[k] = div_step('{den: i_den, rem: '0, nq: i_num});
        end else begin : g_next
            assign n_stg[k] = div_step(r_stg[k-1]);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_quo = r_stg[qs_pkg::NDIV-1].nq;

endmodule

// ===== design/quaternion_slerp.sv =====
// An item runs through the precompute stages, the divider, r_post and then r_out.
// Throughput: one item per cycle; the whole pipeline advances whenever the output
// register is empty or its item is being taken, so a stall freezes every stage.
// The depth is set by the 32-stage restoring divider and the series sine stages.
// Reset is synchronous and active low; it clears all valid bits and loads the
// near-parallel threshold with 32735.
module quaternion_slerp (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [15:0]  i_cfg_wr_data,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [143:0] i_s_tdata,  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [63:0]  o_m_tdata,  // out_x, out_y, out_z, out_w
    output logic         o_m_tuser   // used_linear
);

    logic [15:0]       r_thr;
    logic              w_en;
    qs_pkg::t_pipe     w_in;
    qs_pkg::t_pipe     r_pipe [qs_pkg::NPRE];
    qs_pkg::t_pipe     n_pipe [qs_pkg::NPRE];
    qs_pkg::t_pipe     w_pe;
    qs_pkg::t_side     w_side;
    qs_pkg::t_side     r_side [qs_pkg::NDIV];
    logic [16:0]       w_st;
    logic [16:0]       w_mag;
    logic [16:0]       w_den;
    logic [16:0]       w_lmag;
    logic [3:0][31:0]  w_num;
    logic [3:0][31:0]  w_quo;
    qs_pkg::t_post     r_post;
    qs_pkg::t_post     n_post;
    qs_pkg::t_out      r_out;
    qs_pkg::t_out      n_out;

    assign w_en       = !r_out.vld || i_m_tready;
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= qs_pkg::THR_RESET;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    always_comb begin
        w_in     = '0;
        w_in.vld = i_s_tvalid;
        for (int i = 0; i < 4; i++) begin
            w_in.a[i] = i_s_tdata[16*i +: 16];
            w_in.b[i] = {i_s_tdata[64+16*i+15], i_s_tdata[64+16*i +: 16]};
        end
        w_in.t = i_s_tdata[143:128];
    end

    for (genvar k = 0; k < qs_pkg::NPRE; k++) begin : g_pre
        if (k == 0) begin : g_first
            assign n_pipe[k] = qs_pkg::stage_fn(k, w_in, r_thr);
        end else begin : g_next
            assign n_pipe[k] = qs_pkg::stage_fn(k, r_pipe[k-1], r_thr);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pipe[k].vld <= 1'b0;
            end else if (w_en) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
    end

    assign w_pe  = r_pipe[qs_pkg::NPRE-1];
    assign w_st  = w_pe.sn[0].s;
    assign w_mag = w_pe.sq[1].r[16:0];

    always_comb begin
        w_side       = '0;
        w_side.vld   = w_pe.vld;
        w_side.lin   = w_pe.lin || (w_st == '0);
        w_side.mzero = (w_mag == '0);
        w_side.a     = w_pe.a;
        w_side.b     = w_pe.b;
        w_lmag       = '0;
        if (w_side.lin) begin
            w_den = w_side.mzero ? 17'd1 : w_mag;
        end else begin
            w_den = w_st;
        end
        for (int i = 0; i < 4; i++) begin
            w_side.lneg[i] = w_pe.l[i] < 0;
            w_lmag = w_side.lneg[i] ? 17'(-w_pe.l[i]) : w_pe.l[i];
            if (w_side.lin) begin
                w_num[i] = {w_lmag, 15'b0} + 32'(w_den >> 1);
            end else if (i < 2) begin
                w_num[i] = {w_pe.sn[i+1].s, 15'b0} + 32'(w_den >> 1);
            end else begin
                w_num[i] = '0;
            end
        end
    end

    qs_div u_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_den (w_den),
        .i_num (w_num),
        .o_quo (w_quo)
    );

    for (genvar k = 0; k < qs_pkg::NDIV; k++) begin : g_side
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_side[k].vld <= 1'b0;
                end else if (w_en) begin
                    r_side[k] <= w_side;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_side[k].vld <= 1'b0;
                end else if (w_en) begin
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    always_comb begin
        n_post       = '0;
        n_post.vld   = r_side[qs_pkg::NDIV-1].vld;
        n_post.lin   = r_side[qs_pkg::NDIV-1].lin;
        n_post.mzero = r_side[qs_pkg::NDIV-1].mzero;
        n_post.lneg  = r_side[qs_pkg::NDIV-1].lneg;
        n_post.q     = w_quo;
        for (int i = 0; i < 4; i++) begin
            n_post.pa[i] = r_side[qs_pkg::NDIV-1].a[i] * $signed({1'b0, w_quo[0]});
            n_post.pb[i] = r_side[qs_pkg::NDIV-1].b[i] * $signed({1'b0, w_quo[1]});
        end
    end

    always_comb begin
        n_out     = '0;
        n_out.vld = r_post.vld;
        n_out.lin = r_post.lin;
        for (int i = 0; i < 4; i++) begin
            if (!r_post.lin) begin
                n_out.r[i] = qs_pkg::sat16(qs_pkg::rsh15(r_post.pa[i] + r_post.pb[i]));
            end else if (r_post.mzero) begin
                n_out.r[i] = '0;
            end else if (r_post.lneg[i]) begin
                n_out.r[i] = qs_pkg::sat16(-$signed({18'b0, r_post.q[i]}));
            end else begin
                n_out.r[i] = qs_pkg::sat16($signed({18'b0, r_post.q[i]}));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_post.vld <= 1'b0;
            r_out.vld  <= 1'b0;
        end else if (w_en) begin
            r_post <= n_post;
            r_out  <= n_out;
        end
    end

    assign o_m_tvalid = r_out.vld;
    assign o_m_tdata  = r_out.r;
    assign o_m_tuser  = r_out.lin;

    a_flip_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pipe[2].vld |-> (r_pipe[2].dot >= 0))
        else $error("dot product negative after flip");

    a_sqrt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pe.vld |-> (w_pe.sq[0].r <= 34'd32768))
        else $error("acos square root out of range");

    a_theta_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pe.vld |-> (w_pe.theta <= {1'b0, qs_pkg::HALF_PI}))
        else $error("angle above half pi");

    a_zero_blend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_post.vld && r_post.lin && r_post.mzero) |=> (r_out.r == '0))
        else $error("zero-length blend gave a nonzero result");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

class slerp_scoreboard;
    logic [64:0] pending[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    function void note_input(logic [64:0] exp_res);
        pending.push_back(exp_res);
    endfunction

    function void check_result(logic [63:0] data, logic lin);
        logic [64:0] e;
        string       names[4];
        names = '{"out_x", "out_y", "out_z", "out_w"};
        if (pending.size() == 0) begin
            $error("result with no pending prediction: %h %b", data, lin);
            errors++;
            return;
        end
        e = pending.pop_front();
        for (int i = 0; i < 4; i++) begin
            if (e[16*i +: 16] != data[16*i +: 16]) begin
                $error("%s expected %0d actual %0d", names[i],
                       $signed(e[16*i +: 16]), $signed(data[16*i +: 16]));
                errors++;
            end
        end
        if (e[64] != lin) begin
            $error("used_linear expected %b actual %b", e[64], lin);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int LATENCY = 59;
    localparam int WATCHDOG = 5000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wr_en = 1'b0;
    logic [15:0]  i_cfg_wr_data = '0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [143:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [63:0]  o_m_tdata;
    logic         o_m_tuser;

    slerp_scoreboard sb = new();
    logic [15:0] thr_model;
    bit          no_idle = 1'b0;
    bit          long_hold = 1'b0;
    bit          timed_out = 1'b0;
    int          idle_cycles = 0;
    int          ready_hold = 0;

    quaternion_slerp dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint q15_round(longint v);
        longint q;
        q = v + 16384;
        if (q >= 0) return q / 32768;
        return -((-q + 32767) / 32768);
    endfunction

    function automatic longint div_round(longint n, longint d);
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint arc_cos(longint d);
        longint p, s;
        s = int_sqrt(longint'(32768 - d) << 15);
        p = -614;
        p = 2433 + q15_round(p * d);
        p = -6951 + q15_round(p * d);
        p = 51470 + q15_round(p * d);
        return q15_round(p * s);
    endfunction

    function automatic longint sine(longint y);
        longint unsigned u, y2, t;
        if (y < 0) y = 0;
        if (y > 51472) y = 51472;
        u = y;
        t = 32768;
        y2 = (u * u + 16384) >> 15;
        t = 32768 - (y2 * t + (36 << 15)) / (72 << 15);
        t = 32768 - (y2 * t + (21 << 15)) / (42 << 15);
        t = 32768 - (y2 * t + (10 << 15)) / (20 << 15);
        t = 32768 - (y2 * t + (3 << 15)) / (6 << 15);
        return longint'((u * t + 16384) >> 15);
    endfunction

    function automatic logic [64:0] slerp_predict(logic [143:0] x);
        longint a[4], b[4], r[4], l[4];
        longint dot, d, t, th, st, s0, s1, w0, w1, mag;
        longint unsigned msq;
        logic lin;
        logic [64:0] res;
        dot = 0;
        for (int i = 0; i < 4; i++) begin
            a[i] = $signed(x[16*i +: 16]);
            b[i] = $signed(x[16*(i+4) +: 16]);
            dot += a[i] * b[i];
        end
        t = x[143:128];
        if (t > 32768) t = 32768;
        if (dot < 0) begin
            dot = -dot;
            for (int i = 0; i < 4; i++) b[i] = -b[i];
        end
        d = (dot + 16384) / 32768;
        if (d > 32768) d = 32768;
        lin = d > longint'(thr_model);
        if (!lin) begin
            th = arc_cos(d);
            st = sine(th);
            if (st == 0) begin
                lin = 1'b1;
            end else begin
                s0 = sine(q15_round(th * (32768 - t)));
                s1 = sine(q15_round(th * t));
                w0 = div_round(s0 * 32768, st);
                w1 = div_round(s1 * 32768, st);
                for (int i = 0; i < 4; i++)
                    r[i] = clamp16(q15_round(a[i] * w0 + b[i] * w1));
            end
        end
        if (lin) begin
            msq = 0;
            for (int i = 0; i < 4; i++) begin
                l[i] = q15_round(a[i] * (32768 - t) + b[i] * t);
                msq += longint'(l[i] * l[i]);
            end
            mag = int_sqrt(msq);
            for (int i = 0; i < 4; i++)
                r[i] = (mag == 0) ? 0 : clamp16(div_round(l[i] * 32768, mag));
        end
        for (int i = 0; i < 4; i++) res[16*i +: 16] = r[i][15:0];
        res[64] = lin;
        return res;
    endfunction

    task automatic send_item(logic [143:0] x);
        int gap;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= x;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(slerp_predict(x));
    endtask

    task automatic end_burst();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [15:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        thr_model = v;
        @(posedge i_clk);
    endtask

    function automatic logic [143:0] pack_q(logic [63:0] qa, logic [63:0] qb, logic [15:0] t);
        return {t, qb, qa};
    endfunction

    function automatic logic [63:0] rand_unitish();
        int v[4];
        longint m;
        logic [63:0] q;
        m = 0;
        for (int i = 0; i < 4; i++) begin
            v[i] = int'($urandom_range(0, 65535)) - 32768;
            m += longint'(v[i]) * v[i];
        end
        m = int_sqrt(m);
        if (m == 0) m = 1;
        for (int i = 0; i < 4; i++) q[16*i +: 16] = 16'(clamp16(div_round(v[i] * 32767, m)));
        return q;
    endfunction

    function automatic logic [63:0] nudge(logic [63:0] q, int amt);
        for (int i = 0; i < 4; i++)
            q[16*i +: 16] = 16'(clamp16($signed(q[16*i +: 16]) +
                                 int'($urandom_range(0, 2 * amt)) - amt));
        return q;
    endfunction

    function automatic logic [15:0] rand_blend();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom_range(32769, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic random_items(int n);
        logic [63:0] qa, qb;
        for (int k = 0; k < n; k++) begin
            qa = rand_unitish();
            case ($urandom_range(0, 9))
                0: qb = {$urandom, $urandom};
                1: qb = nudge(qa, 40);
                2: qb = nudge(~qa + 64'h0001_0001_0001_0001, 40);
                3: qb = nudge(qa, 2000);
                default: qb = rand_unitish();
            endcase
            if ($urandom_range(0, 19) == 0) qa = {$urandom, $urandom};
            send_item(pack_q(qa, qb, rand_blend()));
        end
        end_burst();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (long_hold) begin
            i_m_tready <= 1'b0;
        end else if (no_idle) begin
            i_m_tready <= 1'b1;
        end else if (ready_hold > 0) begin
            i_m_tready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_m_tready <= 1'b0;
            ready_hold <= int'($urandom_range(0, 18));
        end else begin
            i_m_tready <= 1'b1;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tuser);
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG && !timed_out) begin
            timed_out = 1'b1;
            $display("quaternion_slerp verification failed");
            $finish;
        end
    end

    initial begin
        logic [63:0] qa;
        thr_model = 16'd32735;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        qa = 64'h0000_0000_0000_7FFF;
        send_item(pack_q(qa, qa, 16'd0));
        send_item(pack_q(qa, qa, 16'd32768));
        send_item(pack_q(qa, qa, 16'hFFFF));
        send_item(pack_q(qa, 64'h8000_0000_0000_0000, 16'd16384));
        send_item(pack_q(qa, 64'h0000_0000_0000_8001, 16'd16384));
        send_item(pack_q(qa, 64'h0000_0000_0000_8001, 16'd0));
        send_item(pack_q(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000, 16'd100));
        send_item(pack_q(64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000, 16'd32768));
        send_item(pack_q(64'h0, 64'h0, 16'd12345));
        send_item(pack_q(qa, 64'h0, 16'd32768));
        send_item(pack_q(qa, 64'h0000_0000_5A82_5A82, 16'd20000));
        send_item(pack_q(64'h7FFF_0000_0000_7FFF, 64'h8001_0000_0000_8001, 16'd16384));
        send_item(pack_q(64'h5555_AAAA_5555_AAAA, 64'hAAAA_5555_AAAA_5555, 16'd8000));
        send_item(pack_q(64'h0001_FFFF_0001_FFFF, 64'hFFFF_0001_FFFF_0001, 16'd32767));
        end_burst();
        drain();

        write_threshold(16'd32768);
        send_item(pack_q(qa, qa, 16'd5000));
        send_item(pack_q(qa, nudge(qa, 10), 16'd5000));
        random_items(150);
        drain();

        write_threshold(16'd0);
        send_item(pack_q(qa, qa, 16'd5000));
        send_item(pack_q(qa, 64'h0000_0000_7FFF_0000, 16'd5000));
        random_items(150);
        drain();

        write_threshold(16'hFFFF);
        random_items(120);
        drain();

        write_threshold(16'($urandom_range(28000, 32767)));
        random_items(200);

        long_hold = 1'b1;
        fork
            random_items(120);
            begin
                repeat (300) @(posedge i_clk);
                long_hold = 1'b0;
            end
        join
        drain();

        write_threshold(16'd32735);
        random_items(200);
        no_idle = 1'b1;
        random_items(100);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("quaternion_slerp verification clean");
        end else begin
            $display("quaternion_slerp verification failed");
        end
        $finish;
    end
endmodule

// ===== quaternion_slerp.f =====
design/qs_pkg.sv
design/qs_div.sv
design/quaternion_slerp.sv
tb/tb_top.sv
